// ===== hw/rtl/go_back_n_link_endpoint_core_assert.svh =====
// Assertion macros used by the endpoint controller RTL.
`ifndef GO_BACK_N_LINK_ENDPOINT_CORE_ASSERT_SVH
`define GO_BACK_N_LINK_ENDPOINT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define GBN_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GBN_ASSERT(lbl, prop, msg)
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/gbn_pkg.sv =====
`default_nettype none

package gbn_pkg;

    localparam int SEQ_BITS     = 3;
    localparam int PAYLOAD_BITS = 32;
    localparam int SEQ_MOD      = 1 << SEQ_BITS;

    localparam int FUNC_BITS   = 2;
    localparam int ACTION_BITS = 3;

    localparam int IN_DATA_W  = ((PAYLOAD_BITS + 2 * SEQ_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((2 * SEQ_BITS + PAYLOAD_BITS + 1 + 7) / 8) * 8;

    localparam logic [SEQ_BITS-1:0] SEQ_MAX  = '1;
    localparam logic [SEQ_BITS-1:0] SEQ_ONE  = SEQ_BITS'(1);
    localparam logic [SEQ_BITS-1:0] SEQ_ZERO = '0;

    localparam logic [FUNC_BITS-1:0] FUNC_SEND    = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_ARRIVE  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CKERR   = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_TIMEOUT = 2'd3;

    localparam logic [ACTION_BITS-1:0] ACT_SEND    = 3'd0;
    localparam logic [ACTION_BITS-1:0] ACT_DELIVER = 3'd1;
    localparam logic [ACTION_BITS-1:0] ACT_STOP    = 3'd2;
    localparam logic [ACTION_BITS-1:0] ACT_NONE    = 3'd3;
    localparam logic [ACTION_BITS-1:0] ACT_FULL    = 3'd4;

    typedef struct packed {
        logic [SEQ_BITS-1:0]     rx_ack;
        logic [SEQ_BITS-1:0]     rx_seq;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [FUNC_BITS-1:0]    func;
    } in_item_t;

    typedef struct packed {
        logic [ACTION_BITS-1:0]  action;
        logic [SEQ_BITS-1:0]     out_seq;
        logic [SEQ_BITS-1:0]     out_ack;
        logic [PAYLOAD_BITS-1:0] out_payload;
        logic                    net_enable;
        logic                    last;
    } res_t;

    // True when a <= b < c on the sequence circle.
    function automatic logic in_window(input logic [SEQ_BITS-1:0] a,
                                       input logic [SEQ_BITS-1:0] b,
                                       input logic [SEQ_BITS-1:0] c);
        in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                    ((b < c) && (c < a));
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbn_ram.sv =====
`default_nettype none

module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gbn_ctrl.sv =====
`default_nettype none
`include "go_back_n_link_endpoint_core_assert.svh"

module gbn_ctrl import gbn_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire in_item_t in_item,
    output logic          res_valid,
    input  wire logic     res_ready,
    output res_t          res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ONE   = 3'd1;
    localparam logic [2:0] ST_STOP  = 3'd2;
    localparam logic [2:0] ST_PRIME = 3'd3;
    localparam logic [2:0] ST_RETX  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SEQ_BITS-1:0] next_reg, next_next;
    logic [SEQ_BITS-1:0] oldest_reg, oldest_next;
    logic [SEQ_BITS-1:0] exp_reg, exp_next;
    logic [SEQ_BITS-1:0] count_reg, count_next;
    logic [SEQ_BITS-1:0] ptr_reg, ptr_next;
    logic [SEQ_BITS-1:0] remain_reg, remain_next;
    logic                net_en_reg, net_en_next;
    res_t                one_reg, one_next;

    logic                    ram_we;
    logic [SEQ_BITS-1:0]     ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    logic                accept;
    logic                full;
    logic                deliver;
    logic [SEQ_BITS-1:0] n_ret;
    logic [SEQ_BITS-1:0] final_count;
    logic [SEQ_BITS-1:0] send_ack;
    logic [SEQ_BITS-1:0] step;
    logic                take;

    gbn_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (SEQ_MOD)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (next_reg),
        .wdata (in_item.payload),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign full        = (count_reg >= SEQ_MAX);
    assign deliver     = (in_item.rx_seq == exp_reg);
    assign n_ret       = in_window(oldest_reg, in_item.rx_ack, next_reg) ?
                         (in_item.rx_ack - oldest_reg + SEQ_ONE) : SEQ_ZERO;
    assign final_count = count_reg - n_ret;
    assign send_ack    = exp_reg - SEQ_ONE;
    assign step        = ptr_reg + SEQ_ONE;
    assign take        = res_valid && res_ready;

    always_comb begin
        state_next  = state_reg;
        next_next   = next_reg;
        oldest_next = oldest_reg;
        exp_next    = exp_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        remain_next = remain_reg;
        net_en_next = net_en_reg;
        one_next    = one_reg;
        ram_we      = 1'b0;
        ram_raddr   = ptr_reg;
        res_valid   = 1'b0;
        res         = one_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    one_next = '{action: ACT_NONE, out_seq: SEQ_ZERO, out_ack: SEQ_ZERO,
                                 out_payload: '0, net_enable: 1'b0, last: 1'b1};
                    net_en_next = (count_reg < SEQ_MAX);
                    remain_next = SEQ_ZERO;
                    ptr_next    = oldest_reg;
                    state_next  = ST_ONE;
                    case (in_item.func)
                        FUNC_SEND: begin
                            if (full) begin
                                one_next.action = ACT_FULL;
                            end else begin
                                ram_we               = 1'b1;
                                one_next.action      = ACT_SEND;
                                one_next.out_seq     = next_reg;
                                one_next.out_ack     = send_ack;
                                one_next.out_payload = in_item.payload;
                                next_next            = next_reg + SEQ_ONE;
                                count_next           = count_reg + SEQ_ONE;
                                net_en_next          = ((count_reg + SEQ_ONE) < SEQ_MAX);
                            end
                        end
                        FUNC_ARRIVE: begin
                            remain_next = n_ret;
                            count_next  = final_count;
                            net_en_next = (final_count < SEQ_MAX);
                            if (n_ret != SEQ_ZERO) begin
                                oldest_next = in_item.rx_ack + SEQ_ONE;
                            end
                            if (deliver) begin
                                one_next.action      = ACT_DELIVER;
                                one_next.out_payload = in_item.payload;
                                one_next.last        = (n_ret == SEQ_ZERO);
                                exp_next             = exp_reg + SEQ_ONE;
                            end else if (n_ret != SEQ_ZERO) begin
                                state_next = ST_STOP;
                            end
                        end
                        FUNC_TIMEOUT: begin
                            if (count_reg != SEQ_ZERO) begin
                                remain_next = count_reg;
                                state_next  = ST_PRIME;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ONE: begin
                res_valid = 1'b1;
                if (take) begin
                    state_next = (remain_reg != SEQ_ZERO) ? ST_STOP : ST_IDLE;
                end
            end
            ST_STOP: begin
                res_valid = 1'b1;
                res = '{action: ACT_STOP, out_seq: ptr_reg, out_ack: SEQ_ZERO,
                        out_payload: '0, net_enable: 1'b0, last: (remain_reg == SEQ_ONE)};
                if (take) begin
                    ptr_next    = step;
                    remain_next = remain_reg - SEQ_ONE;
                    state_next  = (remain_reg == SEQ_ONE) ? ST_IDLE : ST_STOP;
                end
            end
            ST_PRIME: begin
                state_next = ST_RETX;
            end
            ST_RETX: begin
                res_valid = 1'b1;
                res = '{action: ACT_SEND, out_seq: ptr_reg, out_ack: send_ack,
                        out_payload: ram_rdata, net_enable: 1'b0,
                        last: (remain_reg == SEQ_ONE)};
                if (take) begin
                    ram_raddr   = step;
                    ptr_next    = step;
                    remain_next = remain_reg - SEQ_ONE;
                    state_next  = (remain_reg == SEQ_ONE) ? ST_IDLE : ST_RETX;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        res.net_enable = net_en_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            next_reg   <= '0;
            oldest_reg <= '0;
            exp_reg    <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            next_reg   <= next_next;
            oldest_reg <= oldest_next;
            exp_reg    <= exp_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        net_en_reg <= net_en_next;
        one_reg    <= one_next;
    end

    `GBN_ASSERT(a_count_matches_window, count_reg == SEQ_BITS'(next_reg - oldest_reg), "outstanding count disagrees with window")
    `GBN_ASSERT_NEXT(a_last_returns_idle, take && res.last, state_reg == ST_IDLE, "sequencer did not return to idle after the last item")
    `GBN_ASSERT(a_loop_has_work, !((state_reg == ST_STOP || state_reg == ST_RETX || state_reg == ST_PRIME) && remain_reg == SEQ_ZERO), "loop state with nothing left to emit")

endmodule

`default_nettype wire

// ===== hw/rtl/go_back_n_link_endpoint_core.sv =====
// Channel  Direction  tuser          tdata                                      tlast
// s_       in         func           payload, rx_seq, rx_ack                    -
// m_       out        action         out_seq, out_ack, out_payload, net_enable  last
//
// An item is taken while idle; its results follow, one per cycle unless m_tready stalls them.
// A packet, checksum error or arrival goes straight to its results; a timeout that resends
// first passes a prime state for the registered read of the send ring. An arrival can
// deliver and retire up to seven frames, and a timeout can resend up to seven.
// Reset clears the sequence counters; the send ring is not cleared and needs no clearing pass.
// While m_tready is low the output register holds its item and the sequencer waits with the
// next one; once the last result of an item is in the output register a new item is taken.
`default_nettype none

module go_back_n_link_endpoint_core import gbn_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // payload, rx_seq, rx_ack, zero fill
    input  wire logic [FUNC_BITS-1:0]   s_tuser,   // func
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [OUT_DATA_W-1:0]  m_tdata,   // out_seq, out_ack, out_payload, net_enable
    output logic      [ACTION_BITS-1:0] m_tuser,   // action
    output logic                        m_tlast
);

    in_item_t in_item;
    res_t     res;
    logic     res_valid;
    logic     res_ready;
    logic     m_valid_reg;
    res_t     m_res_reg;

    assign in_item.func    = s_tuser;
    assign in_item.payload = s_tdata[PAYLOAD_BITS-1:0];
    assign in_item.rx_seq  = s_tdata[PAYLOAD_BITS +: SEQ_BITS];
    assign in_item.rx_ack  = s_tdata[PAYLOAD_BITS + SEQ_BITS +: SEQ_BITS];

    gbn_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    always_comb begin
        m_tdata = '0;
        m_tdata[SEQ_BITS-1:0]                    = m_res_reg.out_seq;
        m_tdata[SEQ_BITS +: SEQ_BITS]            = m_res_reg.out_ack;
        m_tdata[2 * SEQ_BITS +: PAYLOAD_BITS]    = m_res_reg.out_payload;
        m_tdata[2 * SEQ_BITS + PAYLOAD_BITS]     = m_res_reg.net_enable;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.action;
    assign m_tlast  = m_res_reg.last;

endmodule

`default_nettype wire
